FILE: sv/pcte_pkg.sv
`default_nettype none
package pcte_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int MIN_POINTS = 2;
    localparam int PTR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int GRP        = 8;
    localparam int NGRP       = MAX_POINTS / GRP;
    localparam int GCNT_W     = $clog2(GRP + 1);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic {
        CFG_POINT_COUNT = 1'b0,
        CFG_DRAG_SCALE  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic signed [31:0] bp;
        logic signed [31:0] cub;
        logic signed [31:0] sq;
        logic signed [31:0] lin;
        logic signed [31:0] cst;
    } t_entry;

    // item state ahead of the coefficient memory
    typedef struct packed {
        logic               valid;
        logic               eval;
        logic               err;
        logic [PTR_W-1:0]   idx;
        logic signed [31:0] q;
        t_entry             ent;
    } t_front;

    // item state through the horner chain
    typedef struct packed {
        logic               valid;
        logic               err;
        logic [PTR_W-1:0]   seg;
        logic signed [31:0] dx;
        logic signed [31:0] lin;
        logic signed [31:0] cst;
    } t_ctx;

    function automatic logic signed [31:0] f_sat(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
        else                            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/pcte_horner.sv
`default_nettype none
module pcte_horner (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire pcte_pkg::t_ctx     i_ctx,
    input  wire logic signed [31:0] i_acc,
    input  wire logic signed [31:0] i_coef,
    output pcte_pkg::t_ctx          o_ctx,
    output logic signed [31:0]      o_acc
);
    import pcte_pkg::*;

    t_ctx               r_ctx_a;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_coef;
    t_ctx               r_ctx_b;
    logic signed [31:0] r_acc;
    logic signed [65:0] n_sum;

    // round to nearest, ties up, then add the coefficient
    always_comb begin
        n_sum = ($signed({{2{r_prod[63]}}, r_prod}) + (66'sd1 <<< (FRAC_BITS - 1)))
                >>> FRAC_BITS;
        n_sum = n_sum + $signed({{34{r_coef[31]}}, r_coef});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_a.valid <= 1'b0;
            r_ctx_b.valid <= 1'b0;
        end else if (i_en) begin
            r_ctx_a <= i_ctx;
            r_ctx_b <= r_ctx_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_acc * i_ctx.dx;
            r_coef <= i_coef;
            r_acc  <= f_sat(n_sum);
        end
    end

    assign o_ctx = r_ctx_b;
    assign o_acc = r_acc;
endmodule
`default_nettype wire

FILE: sv/piecewise_cubic_table_eval_core.sv
`default_nettype none
// Piecewise cubic table evaluator. A load beat (op 0) writes one table entry:
// a breakpoint and the four coefficients of the cubic segment starting there.
// An evaluate beat (op 1) picks the segment whose breakpoint lies just below
// the query (edge segments extrapolate), evaluates d + dx*(c + dx*(b + dx*a))
// with dx = query - breakpoint, and also returns that value times drag_scale
// (32 fraction bits). All values are signed Q16.16, rounded to nearest and
// saturated. Fewer than two points give status 1 and zero results. Loads give
// no output beat. The block takes one beat every cycle unless the output beat
// is held; an evaluate passes compare, two-level count, segment clamp, memory
// read, dx, three two-stage horner steps, drag product and output register.
// Configuration must be written by the user only while the pipeline is empty,
// unenforced by the block; entries must be loaded before they are evaluated.
module piecewise_cubic_table_eval_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_op,
    input  wire logic [5:0]         i_entry_index,
    input  wire logic signed [31:0] i_breakpoint,
    input  wire logic signed [31:0] i_coef_cubic,
    input  wire logic signed [31:0] i_coef_square,
    input  wire logic signed [31:0] i_coef_linear,
    input  wire logic signed [31:0] i_coef_const,
    input  wire logic signed [31:0] i_query,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_curve_value,
    output logic signed [31:0]      o_scaled_drag,
    output logic [5:0]              o_segment_used,
    output logic                    o_status
);
    import pcte_pkg::*;

    // config registers
    logic [CNT_W-1:0] r_point_count;
    logic [31:0]      r_drag_scale;
    logic [CNT_W-1:0] n_eff;

    // global advance: everything moves unless the output beat is held
    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_drag_scale  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_POINT_COUNT: r_point_count <= i_cfg_data[CNT_W-1:0];
                CFG_DRAG_SCALE:  r_drag_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // counts above the table depth act as a full table
    assign n_eff = (r_point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                        : r_point_count;

    // breakpoint cells, one comparator each; written as a load is taken so
    // every later evaluate sees it
    logic signed [31:0] r_bp_cell [MAX_POINTS];
    logic [MAX_POINTS-1:0] n_mask;
    logic in_take;
    assign in_take = i_in_valid && en;

    always_ff @(posedge i_clk) begin
        if (in_take && t_op'(i_op) == OP_LOAD)
            r_bp_cell[i_entry_index] <= i_breakpoint;
    end

    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++)
            n_mask[i] = (CNT_W'(i) < n_eff) && (r_bp_cell[i] < i_query);
    end

    // stage 1: below-query mask
    t_front                r1;
    logic [MAX_POINTS-1:0] r1_mask;
    t_front                n_front;

    always_comb begin
        n_front.valid   = i_in_valid;
        n_front.eval    = (t_op'(i_op) == OP_EVAL);
        n_front.err     = (n_eff < CNT_W'(MIN_POINTS));
        n_front.idx     = i_entry_index;
        n_front.q       = i_query;
        n_front.ent.bp  = i_breakpoint;
        n_front.ent.cub = i_coef_cubic;
        n_front.ent.sq  = i_coef_square;
        n_front.ent.lin = i_coef_linear;
        n_front.ent.cst = i_coef_const;
    end

    // stage 2: per-group counts
    t_front            r2;
    logic [GCNT_W-1:0] r2_gcnt [NGRP];
    logic [GCNT_W-1:0] n_gcnt  [NGRP];

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_gcnt[g] = '0;
            for (int b = 0; b < GRP; b++)
                n_gcnt[g] = n_gcnt[g] + GCNT_W'(r1_mask[g*GRP + b]);
        end
    end

    // stage 3: total count, segment clamp to 0..n-2
    t_front           r3;
    logic [PTR_W-1:0] r3_seg;
    logic [CNT_W-1:0] n_below;
    logic [CNT_W-1:0] n_segw;
    logic [CNT_W-1:0] n_top;

    always_comb begin
        n_below = '0;
        for (int g = 0; g < NGRP; g++)
            n_below = n_below + CNT_W'(r2_gcnt[g]);
        n_segw = (n_below == '0) ? '0 : n_below - CNT_W'(1);
        n_top  = n_eff - CNT_W'(MIN_POINTS);
        if (n_segw > n_top) n_segw = n_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1.valid <= 1'b0;
            r2.valid <= 1'b0;
            r3.valid <= 1'b0;
        end else if (en) begin
            r1 <= n_front;
            r2 <= r1;
            r3 <= r2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mask <= n_mask;
            r2_gcnt <= n_gcnt;
            r3_seg  <= n_segw[PTR_W-1:0];
        end
    end

    // stage 4: coefficient memory; loads write here so reads stay in order
    t_entry             r_mem [MAX_POINTS];
    t_entry             r4_ent;
    logic               r4_valid;
    logic               r4_err;
    logic [PTR_W-1:0]   r4_seg;
    logic signed [31:0] r4_q;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r3.valid && !r3.eval)
                r_mem[r3.idx] <= r3.ent;
            r4_ent <= r_mem[r3_seg];
            r4_err <= r3.err;
            r4_seg <= r3_seg;
            r4_q   <= r3.q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r4_valid <= 1'b0;
        else if (en)   r4_valid <= r3.valid && r3.eval;
    end

    // stage 5: dx, saturated
    t_ctx               r5;
    logic signed [31:0] r5_cub;
    logic signed [31:0] r5_sq;
    logic signed [32:0] n_dx;

    assign n_dx = $signed({r4_q[31], r4_q}) - $signed({r4_ent.bp[31], r4_ent.bp});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5.valid <= 1'b0;
        end else if (en) begin
            r5.valid <= r4_valid;
            r5.err   <= r4_err;
            r5.seg   <= r4_seg;
            r5.dx    <= f_sat({{33{n_dx[32]}}, n_dx});
            r5.lin   <= r4_ent.lin;
            r5.cst   <= r4_ent.cst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_cub <= r4_ent.cub;
            r5_sq  <= r4_ent.sq;
        end
    end

    // three horner steps, two stages each
    t_ctx               h1_ctx, h2_ctx, h3_ctx;
    logic signed [31:0] h1_acc, h2_acc, h3_acc;

    pcte_horner u_h1 (
        .i_clk, .i_rst_n, .i_en(en),
        .i_ctx(r5), .i_acc(r5_cub), .i_coef(r5_sq),
        .o_ctx(h1_ctx), .o_acc(h1_acc)
    );
    pcte_horner u_h2 (
        .i_clk, .i_rst_n, .i_en(en),
        .i_ctx(h1_ctx), .i_acc(h1_acc), .i_coef(h1_ctx.lin),
        .o_ctx(h2_ctx), .o_acc(h2_acc)
    );
    pcte_horner u_h3 (
        .i_clk, .i_rst_n, .i_en(en),
        .i_ctx(h2_ctx), .i_acc(h2_acc), .i_coef(h2_ctx.cst),
        .o_ctx(h3_ctx), .o_acc(h3_acc)
    );

    // drag product: signed curve value times unsigned scale
    logic               r12_valid;
    logic               r12_err;
    logic [PTR_W-1:0]   r12_seg;
    logic signed [31:0] r12_y;
    logic signed [64:0] r12_prod;
    logic signed [65:0] n_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r12_valid <= 1'b0;
        else if (en)   r12_valid <= h3_ctx.valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_err  <= h3_ctx.err;
            r12_seg  <= h3_ctx.seg;
            r12_y    <= h3_acc;
            r12_prod <= h3_acc * $signed({1'b0, r_drag_scale});
        end
    end

    // round away 32 fraction bits, ties up
    assign n_scaled = ($signed({r12_prod[64], r12_prod}) + (66'sd1 <<< 31)) >>> 32;

    // output register; error beats read as zeros with status set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  o_out_valid <= 1'b0;
        else if (en)   o_out_valid <= r12_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_status <= r12_err;
            if (r12_err) begin
                o_curve_value  <= '0;
                o_scaled_drag  <= '0;
                o_segment_used <= '0;
            end else begin
                o_curve_value  <= r12_y;
                o_scaled_drag  <= f_sat(n_scaled);
                o_segment_used <= r12_seg;
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/pcte_checker.sv
`default_nettype none
module pcte_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [31:0] o_curve_value,
    input wire logic signed [31:0] o_scaled_drag,
    input wire logic [5:0]         o_segment_used,
    input wire logic               o_status
);
    // held output beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_curve_value)
            && $stable(o_scaled_drag) && $stable(o_segment_used))
        else $error("output beat changed while stalled");

    // error beats carry zeros
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_curve_value == 0 && o_scaled_drag == 0
            && o_segment_used == 0)
        else $error("error beat with nonzero payload");

    // input only backs up behind a held output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // segment never past the last pair of points
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_segment_used <= 6'd62)
        else $error("segment index out of range");
endmodule

bind piecewise_cubic_table_eval_core pcte_checker u_pcte_checker (
    .i_clk, .i_rst_n, .o_in_stall, .o_out_valid, .i_out_stall,
    .o_curve_value, .o_scaled_drag, .o_segment_used, .o_status
);
`default_nettype wire

FILE: sim/tb_piecewise_cubic_table_eval_core.sv
`timescale 1ns / 1ps
module tb_piecewise_cubic_table_eval_core;
    import pcte_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 24;   // pipeline is 13 deep, leave margin
    localparam int EVAL_TARGET = 1500;

    typedef struct {
        int       curve;
        int       scaled;
        bit [5:0] seg;
        bit       status;
    } t_drag_result;

    // spline table model plus queue of results still owed by the block
    class spline_scoreboard;
        int           bp_tab[MAX_POINTS];
        int           cub_tab[MAX_POINTS];
        int           sq_tab[MAX_POINTS];
        int           lin_tab[MAX_POINTS];
        int           cst_tab[MAX_POINTS];
        bit [6:0]     point_count;
        bit [31:0]    drag_scale;
        t_drag_result owed[$];
        int           errors;
        int           evals_seen;
        int           err_status_seen;

        function int sat32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return int'(v);
        endfunction

        // one horner step: rounded fixed-point product plus coefficient
        function int horner_step(int acc, int dx, int coef);
            longint p;
            p = (longint'(acc) * longint'(dx) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            return sat32(p + longint'(coef));
        endfunction

        function void set_reg(t_cfg_index idx, bit [31:0] data);
            if (idx == CFG_POINT_COUNT) point_count = data[6:0];
            else drag_scale = data;
        endfunction

        function void note_beat(t_op op, bit [5:0] idx, int bp, int cub, int sq, int lin,
                                int cst, int q);
            t_drag_result r;
            int n, below, seg, dx, y;
            if (op == OP_LOAD) begin
                bp_tab[idx] = bp; cub_tab[idx] = cub; sq_tab[idx] = sq;
                lin_tab[idx] = lin; cst_tab[idx] = cst;
                return;
            end
            n = (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
            r = '{0, 0, 6'd0, 1'b1};
            if (n >= MIN_POINTS) begin
                below = 0;
                for (int i = 0; i < n; i++) if (bp_tab[i] < q) below++;
                seg = (below == 0) ? 0 : below - 1;
                if (seg > n - 2) seg = n - 2;
                dx = sat32(longint'(q) - longint'(bp_tab[seg]));
                y = horner_step(cub_tab[seg], dx, sq_tab[seg]);
                y = horner_step(y, dx, lin_tab[seg]);
                y = horner_step(y, dx, cst_tab[seg]);
                r.curve = y;
                r.scaled = sat32((longint'(y) * longint'(drag_scale) + (64'sd1 <<< 31)) >>> 32);
                r.seg = seg[5:0];
                r.status = 1'b0;
            end
            owed = {owed, r};
        endfunction

        function void check_beat(int curve, int scaled, bit [5:0] seg, bit status);
            t_drag_result e;
            evals_seen++;
            if (owed.size() == 0) begin
                $display("%0t: unexpected output beat curve=%h", $time, curve);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (status) err_status_seen++;
            if (curve != e.curve) begin
                $display("%0t: curve_value exp %h got %h", $time, e.curve, curve); errors++;
            end
            if (scaled != e.scaled) begin
                $display("%0t: scaled_drag exp %h got %h", $time, e.scaled, scaled); errors++;
            end
            if (seg != e.seg) begin
                $display("%0t: segment_used exp %0d got %0d", $time, e.seg, seg); errors++;
            end
            if (status != e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, status); errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [31:0]       i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_op = 1'b0;
    logic [5:0]        i_entry_index = '0;
    logic signed [31:0] i_breakpoint = '0;
    logic signed [31:0] i_coef_cubic = '0;
    logic signed [31:0] i_coef_square = '0;
    logic signed [31:0] i_coef_linear = '0;
    logic signed [31:0] i_coef_const = '0;
    logic signed [31:0] i_query = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [31:0] o_curve_value;
    logic signed [31:0] o_scaled_drag;
    logic [5:0]        o_segment_used;
    logic              o_status;

    piecewise_cubic_table_eval_core u_top (.*);

    spline_scoreboard sb = new();
    bit  quiet;                       // no gaps and no stall on either side
    int  cycle_cnt;
    int  stall_left;
    bit  stall_mode;
    int  eval_beats;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: sample pre-edge values, then pick the next stall level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_curve_value, o_scaled_drag, o_segment_used, o_status);
        if (quiet) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_mode = ($urandom_range(0, 2) == 0);
            i_out_stall <= stall_mode;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 3);
        end
    end

    function int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one input beat: hold until taken, then note it for prediction
    task automatic send_beat(t_op op, bit [5:0] idx, int bp, int cub, int sq, int lin,
                             int cst, int q);
        int gap;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_entry_index <= idx;
        i_breakpoint <= bp;
        i_coef_cubic <= cub;
        i_coef_square <= sq;
        i_coef_linear <= lin;
        i_coef_const <= cst;
        i_query <= q;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(op, idx, bp, cub, sq, lin, cst, q);
        if (op == OP_EVAL) eval_beats++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_entry(bit [5:0] idx, int bp, int cub, int sq, int lin, int cst);
        send_beat(OP_LOAD, idx, bp, cub, sq, lin, cst, $urandom);
    endtask

    // evaluate beat, random junk on the load-only fields
    task automatic eval_at(int q);
        send_beat(OP_EVAL, 6'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, q);
    endtask

    // wait for the pipeline to empty before touching registers
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, bit [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function int rand_coef();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $signed($urandom_range(0, 32'h0000_1000)) - 32'sh0000_0800;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // fill entries 0..n-1: ascending breakpoints mostly, sometimes scrambled
    task automatic fill_table(int n);
        int bp;
        bit scramble;
        scramble = ($urandom_range(0, 7) == 0);
        bp = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        for (int i = 0; i < n; i++) begin
            load_entry(i[5:0], scramble ? int'($urandom) : bp,
                       rand_coef(), rand_coef(), rand_coef(), rand_coef());
            bp = bp + $urandom_range(1, 32'h0002_0000);
        end
    endtask

    function int rand_query(int n);
        int k;
        if (n < 2) return $urandom;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: return sb.bp_tab[k];
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return sb.bp_tab[k] + $signed($urandom_range(0, 32'h0002_0000))
                            - 32'sh0000_8000;
        endcase
    endfunction

    task automatic run_phase(bit [6:0] count, bit [31:0] scale, int evals);
        int n, q;
        settle();
        write_reg(CFG_POINT_COUNT, {25'd0, count});
        write_reg(CFG_DRAG_SCALE, scale);
        n = (count > MAX_POINTS) ? MAX_POINTS : count;
        quiet = ($urandom_range(0, 5) == 0);
        if (n >= 2) fill_table(n);
        for (int i = 0; i < evals; i++) begin
            // a few reloads inside the active table, never past it
            if (n >= 2 && $urandom_range(0, 9) == 0) begin
                q = $urandom_range(0, n - 1);
                load_entry(q[5:0], sb.bp_tab[q] + $signed($urandom_range(0, 64)) - 32,
                           rand_coef(), rand_coef(), rand_coef(), rand_coef());
            end
            eval_at(rand_query(n));
        end
    endtask

    initial begin
        bit [6:0] cnt;
        bit [31:0] scl;
        cycle_cnt = 0;
        quiet = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty and single-point tables report the error status
        write_reg(CFG_POINT_COUNT, 32'd0);
        eval_at(32'sh8000_0000);
        eval_at(32'sh7FFF_FFFF);
        settle();
        write_reg(CFG_POINT_COUNT, 32'd1);
        write_reg(CFG_DRAG_SCALE, 32'hFFFF_FFFF);
        eval_at(32'sh0001_0000);
        settle();

        // three points with extreme coefficients, queries at both ends and in between
        write_reg(CFG_POINT_COUNT, 32'd3);
        load_entry(6'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   32'sh8000_0000);
        load_entry(6'd1, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000,
                   32'sh0000_8000);
        load_entry(6'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sh7FFF_FFFF);
        eval_at(32'sh8000_0000);
        eval_at(32'sh8000_0001);
        eval_at(32'sh0000_0000);
        eval_at(32'sh0000_0001);
        eval_at(32'shFFFF_FFFF);
        eval_at(32'sh7FFF_FFFF);
        eval_at(32'sh0001_8000);
        // middle breakpoint moved: counting rule still picks the segment
        load_entry(6'd1, 32'sh4000_0000, 32'sh0000_0100, 32'shFFFF_0000, 32'sh0002_0000,
                   32'shFFFF_8000);
        eval_at(32'sh2000_0000);
        eval_at(32'sh5000_0000);
        settle();
        // count above the table size acts as a full table
        write_reg(CFG_POINT_COUNT, 32'd127);
        write_reg(CFG_DRAG_SCALE, 32'd0);
        fill_table(MAX_POINTS);
        eval_at(32'sh7FFF_FFFF);
        eval_at(32'sh8000_0000);
        eval_at(sb.bp_tab[MAX_POINTS-1]);

        // random phases over counts and drag scales, extremes included
        while (eval_beats < EVAL_TARGET) begin
            case ($urandom_range(0, 7))
                0: cnt = 7'd2;
                1: cnt = 7'd64;
                2: cnt = 7'($urandom_range(65, 127));
                3: cnt = 7'($urandom_range(0, 1));
                default: cnt = 7'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 4))
                0: scl = 32'd0;
                1: scl = 32'hFFFF_FFFF;
                2: scl = $urandom_range(32'd50_000, 32'd2_000_000);
                default: scl = $urandom;
            endcase
            run_phase(cnt, scl, $urandom_range(30, 150));
        end
        settle();

        $display("%0d evaluate beats and %0d error-status results checked, %0d cycles",
                 sb.evals_seen, sb.err_status_seen, cycle_cnt);
        $display("table sizes from empty to over-full, drag scale from zero to maximum");
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/pcte_pkg.sv
sv/pcte_horner.sv
sv/piecewise_cubic_table_eval_core.sv
sv/pcte_checker.sv
sim/tb_piecewise_cubic_table_eval_core.sv
